// ===== rtl/core/swr_pkg.sv =====
// ============================================================================
// swr_pkg
// Shared types and constants for the byte stack with push, pop and roll.
// ============================================================================
`default_nettype none

package swr_pkg;

    // Default number of stack cells.
    localparam int unsigned STACK_DEPTH = 16;

    // Fixed payload field widths.
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned AMT_W   = 8;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned DEPTH_W = 5;

    // Bit counter width of the remainder unit.
    localparam int unsigned REM_CTR_W = $clog2(AMT_W);

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROLL = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PUSH_FULL = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ROLL_ERR  = 2'd3;

    // Per-cell load selection.
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_ABOVE = 2'd1,
        CELL_BELOW = 2'd2,
        CELL_WRAP  = 2'd3
    } cell_op_t;

    // Input transaction payload.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] push_value;
        logic [CNT_W-1:0]  roll_count;
        logic [AMT_W-1:0]  roll_amount;
    } in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [DATA_W-1:0]  data_out;
        logic [STAT_W-1:0]  status;
        logic [DEPTH_W-1:0] depth;
    } out_t;

endpackage

`default_nettype wire

// ===== rtl/core/stack_with_roll_core.sv =====
// Push, pop, a rejected operation and a roll with count zero: result valid in the
// cycle after the input transaction, one transaction per cycle while results drain.
// Valid roll: the bit-serial remainder unit reduces roll_amount mod roll_count,
// then the cell chain rotates by one position per cycle that many times.
// Reset clears the fill count and the handshake state; cell contents stay undefined.
// ============================================================================
// stack_with_roll_core
// Byte stack built as a chain of cells, top of stack in cell 0, with push,
// pop and roll of the top entries.
// ============================================================================
`default_nettype none

module stack_with_roll_core #(
    parameter int unsigned STACK_DEPTH = swr_pkg::STACK_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire swr_pkg::in_t   s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output swr_pkg::out_t       m_data
);

    localparam int unsigned FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned CMP_W  = FILL_W + swr_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_ROT  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                         state_reg,  state_next;
    logic [FILL_W-1:0]              fill_reg,   fill_next;
    logic                           m_valid_reg, m_valid_next;
    swr_pkg::out_t                  out_reg,    out_next;
    logic [swr_pkg::CNT_W-1:0]      roll_n_reg, roll_n_next;
    logic [swr_pkg::CNT_W-1:0]      steps_reg,  steps_next;

    swr_pkg::cell_op_t              cell_op [STACK_DEPTH];
    logic [swr_pkg::DATA_W-1:0]     cell_q  [STACK_DEPTH];
    logic [swr_pkg::DATA_W-1:0]     top_or_zero;
    logic                           out_free;
    logic                           s_fire;
    logic                           rem_start;
    logic                           rem_done;
    logic [swr_pkg::CNT_W-1:0]      rem_val;

    assign out_free    = !m_valid_reg || m_ready;
    assign s_ready     = (state_reg == S_IDLE) && out_free;
    assign s_fire      = s_valid && s_ready;
    assign top_or_zero = (fill_reg == '0) ? '0 : cell_q[0];

    // Chain of cells; cell 0 is the top of the stack.
    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [swr_pkg::DATA_W-1:0] above;
        logic [swr_pkg::DATA_W-1:0] below;

        if (i == 0) begin : g_first
            assign above = s_data.push_value;
        end else begin : g_mid_up
            assign above = cell_q[i-1];
        end

        if (i == STACK_DEPTH - 1) begin : g_last
            assign below = '0;
        end else begin : g_mid_dn
            assign below = cell_q[i+1];
        end

        swr_cell u_cell (
            .aclk    (aclk),
            .op      (cell_op[i]),
            .above_i (above),
            .below_i (below),
            .wrap_i  (cell_q[0]),
            .data_o  (cell_q[i])
        );
    end

    // Remainder of the roll amount by the roll count.
    swr_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (s_data.roll_amount),
        .divisor  (s_data.roll_count),
        .rem_o    (rem_val),
        .done_o   (rem_done)
    );

    // Sequencer: push and pop on acceptance; rolls through S_DIV, S_ROT, S_DONE.
    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;
        roll_n_next  = roll_n_reg;
        steps_next   = steps_reg;
        rem_start    = 1'b0;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            cell_op[i] = swr_pkg::CELL_HOLD;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    m_valid_next     = 1'b1;
                    out_next.status  = swr_pkg::STAT_OK;
                    out_next.data_out = top_or_zero;
                    if (s_data.mode == swr_pkg::MODE_PUSH) begin
                        if (fill_reg == FILL_W'(STACK_DEPTH)) begin
                            out_next.status = swr_pkg::STAT_PUSH_FULL;
                        end else begin
                            for (int i = 0; i < STACK_DEPTH; i++) begin
                                cell_op[i] = swr_pkg::CELL_ABOVE;
                            end
                            fill_next         = fill_reg + 1'b1;
                            out_next.data_out = s_data.push_value;
                        end
                    end else if (s_data.mode == swr_pkg::MODE_POP) begin
                        if (fill_reg == '0) begin
                            out_next.status = swr_pkg::STAT_POP_EMPTY;
                        end else begin
                            for (int i = 0; i < STACK_DEPTH; i++) begin
                                cell_op[i] = swr_pkg::CELL_BELOW;
                            end
                            fill_next = fill_reg - 1'b1;
                        end
                    end else if (s_data.mode == swr_pkg::MODE_ROLL) begin
                        if (CMP_W'(s_data.roll_count) > CMP_W'(fill_reg)) begin
                            out_next.status = swr_pkg::STAT_ROLL_ERR;
                        end else if (s_data.roll_count != '0) begin
                            // Result comes once the rotation is finished.
                            m_valid_next = 1'b0;
                            rem_start    = 1'b1;
                            roll_n_next  = s_data.roll_count;
                            state_next   = S_DIV;
                        end
                    end
                    out_next.depth = swr_pkg::DEPTH_W'(fill_next);
                end
            end
            S_DIV: begin
                if (rem_done) begin
                    steps_next = rem_val;
                    state_next = (rem_val == '0) ? S_DONE : S_ROT;
                end
            end
            S_ROT: begin
                // One-position rotation of the top roll_n cells toward the top.
                for (int i = 0; i < STACK_DEPTH; i++) begin
                    if (i + 1 < int'(roll_n_reg)) begin
                        cell_op[i] = swr_pkg::CELL_BELOW;
                    end else if (i + 1 == int'(roll_n_reg)) begin
                        cell_op[i] = swr_pkg::CELL_WRAP;
                    end
                end
                steps_next = steps_reg - 1'b1;
                if (steps_reg == swr_pkg::CNT_W'(1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    out_next.data_out = top_or_zero;
                    out_next.status   = swr_pkg::STAT_OK;
                    out_next.depth    = swr_pkg::DEPTH_W'(fill_reg);
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and roll bookkeeping registers.
    always_ff @(posedge aclk) begin
        out_reg    <= out_next;
        roll_n_reg <= roll_n_next;
        steps_reg  <= steps_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/swr_cell.sv =====
// ============================================================================
// swr_cell
// One stack cell: holds a byte and loads from its upper or lower neighbor,
// from the top cell, or keeps its value.
// ============================================================================
`default_nettype none

module swr_cell (
    input  wire logic                         aclk,
    input  wire swr_pkg::cell_op_t            op,
    input  wire logic [swr_pkg::DATA_W-1:0]   above_i,
    input  wire logic [swr_pkg::DATA_W-1:0]   below_i,
    input  wire logic [swr_pkg::DATA_W-1:0]   wrap_i,
    output logic      [swr_pkg::DATA_W-1:0]   data_o
);

    logic [swr_pkg::DATA_W-1:0] data_reg;
    logic [swr_pkg::DATA_W-1:0] data_next;

    // Select the next content of the cell.
    always_comb begin
        unique case (op)
            swr_pkg::CELL_ABOVE: data_next = above_i;
            swr_pkg::CELL_BELOW: data_next = below_i;
            swr_pkg::CELL_WRAP:  data_next = wrap_i;
            default:             data_next = data_reg;
        endcase
    end

    // Payload register; its content is undefined until written.
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_o = data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/swr_rem.sv =====
// ============================================================================
// swr_rem
// Restoring remainder unit: roll amount modulo roll count, one dividend bit
// per cycle.
// ============================================================================
`default_nettype none

module swr_rem (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [swr_pkg::AMT_W-1:0]   dividend,
    input  wire logic [swr_pkg::CNT_W-1:0]   divisor,
    output logic      [swr_pkg::CNT_W-1:0]   rem_o,
    output logic                             done_o
);

    logic                           busy_reg,  busy_next;
    logic                           done_reg,  done_next;
    logic [swr_pkg::REM_CTR_W-1:0]  cnt_reg,   cnt_next;
    logic [swr_pkg::AMT_W-1:0]      sh_reg,    sh_next;
    logic [swr_pkg::CNT_W-1:0]      rem_reg,   rem_next;
    logic [swr_pkg::CNT_W-1:0]      div_reg,   div_next;
    logic [swr_pkg::CNT_W:0]        trial;

    // Shift in the next dividend bit and subtract the divisor where it fits.
    assign trial = {rem_reg, sh_reg[swr_pkg::AMT_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = swr_pkg::REM_CTR_W'(swr_pkg::AMT_W - 1);
            sh_next   = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            sh_next = {sh_reg[swr_pkg::AMT_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = swr_pkg::CNT_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[swr_pkg::CNT_W-1:0];
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rem_o  = rem_reg;
    assign done_o = done_reg;

endmodule

`default_nettype wire
